@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, operation codes and cell control type for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int FUNC_W = 3;
  localparam int WORD_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_LEFT  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_RIGHT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_LEFT   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_RIGHT  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

  // Broadcast controls, the same for every cell in the row.
  typedef struct packed {
    logic shift_right;  // push left: every cell takes its left neighbor
    logic shift_left;   // pop left: every cell takes its right neighbor
    logic load_sel;     // push right: selected cell takes the push word
    logic grab_sel;     // pop right: selected cell launches its word on the lane
    logic lane_step;    // return lane moves one cell toward cell 0
  } cell_ctrl_t;

endpackage

@@ rtl/deq_in_if.sv @@
// ----------------------------------------------------------------------------
// deq_in_if
// Request channel: operation code and push word with valid/ready.
// ----------------------------------------------------------------------------
interface deq_in_if;
  import deq_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [WORD_W-1:0] push_word;

  modport source (output valid, func, push_word, input ready);
  modport sink   (input valid, func, push_word, output ready);

endinterface

@@ rtl/deq_out_if.sv @@
// ----------------------------------------------------------------------------
// deq_out_if
// Response channel: popped word and status flags with valid/ready.
// ----------------------------------------------------------------------------
interface deq_out_if;
  import deq_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] pop_word;
  logic              pop_valid;
  logic              is_empty;
  logic              is_full;
  logic              op_error;

  modport source (output valid, pop_word, pop_valid, is_empty, is_full, op_error,
                  input ready);
  modport sink   (input valid, pop_word, pop_valid, is_empty, is_full, op_error,
                  output ready);

endinterface

@@ rtl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row: holds one entry, shifts with its
// neighbors, and carries one stage of the leftward return lane.
// ----------------------------------------------------------------------------
module deq_cell #(
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  deq_pkg::cell_ctrl_t     ctrl_i,
  input  logic [CNT_W-1:0]        sel_i,
  input  logic [DATA_WIDTH-1:0]   push_word_i,
  input  logic [DATA_WIDTH-1:0]   left_word_i,
  input  logic [DATA_WIDTH-1:0]   right_word_i,
  output logic [DATA_WIDTH-1:0]   word_o,
  input  logic                    lane_vld_i,
  input  logic [DATA_WIDTH-1:0]   lane_word_i,
  output logic                    lane_vld_o,
  output logic [DATA_WIDTH-1:0]   lane_word_o
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic                  lane_vld_q, lane_vld_d;
  logic [DATA_WIDTH-1:0] lane_word_q, lane_word_d;
  logic                  hit;

  assign hit = (sel_i == CNT_W'(IDX));

  always_comb begin
    word_d = word_q;
    if (ctrl_i.shift_right) begin
      word_d = left_word_i;
    end else if (ctrl_i.shift_left) begin
      word_d = right_word_i;
    end else if (ctrl_i.load_sel && hit) begin
      word_d = push_word_i;
    end
  end

  always_comb begin
    lane_vld_d  = lane_vld_q;
    lane_word_d = lane_word_q;
    if (ctrl_i.grab_sel && hit) begin
      lane_vld_d  = 1'b1;
      lane_word_d = word_q;
    end else if (ctrl_i.lane_step) begin
      lane_vld_d  = lane_vld_i;
      lane_word_d = lane_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q      <= word_d;
    lane_word_q <= lane_word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= 1'b0;
    end else begin
      lane_vld_q <= lane_vld_d;
    end
  end

  assign word_o      = word_q;
  assign lane_vld_o  = lane_vld_q;
  assign lane_word_o = lane_word_q;

endmodule

@@ rtl/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The left end of the queue always sits in cell 0 and entries occupy cells
// 0 to count-1. For every request other than a pop right on a nonempty
// queue, the response word is registered at the edge that takes the request.
// On a pop right, the tail cell drops its entry onto a return lane that moves
// one cell per cycle to cell 0, where it is registered as the response. A new
// request is taken once no pop right is in flight and the response register
// is free or being read in the same cycle. A pop reads only cells that a push
// wrote, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_in_if.sink    req_i,
  deq_out_if.source rsp_o
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int XW    = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  busy_q, busy_d;
  logic                  out_vld_q, out_vld_d;
  logic [WORD_W-1:0]     out_word_q, out_word_d;
  logic                  out_pv_q, out_pv_d;
  logic                  out_empty_q, out_empty_d;
  logic                  out_full_q, out_full_d;
  logic                  out_err_q, out_err_d;

  cell_ctrl_t            ctrl;
  logic [CNT_W-1:0]      sel;
  logic                  accept;
  logic                  is_empty_now, is_full_now;
  logic                  write_now, defer;
  logic                  pop_now;
  logic                  err_now;
  logic [XW-1:0]         push_ext;
  logic [DATA_WIDTH-1:0] push_word;
  logic [XW-1:0]         head_ext;
  logic [XW-1:0]         lane_ext;

  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic                  lane_vld  [DEPTH+1];
  logic [DATA_WIDTH-1:0] lane_word [DEPTH+1];

  assign push_ext  = XW'(req_i.push_word);
  assign push_word = push_ext[DATA_WIDTH-1:0];
  assign head_ext  = XW'(cell_word[0]);
  assign lane_ext  = XW'(lane_word[0]);

  assign req_i.ready  = !busy_q && (!out_vld_q || rsp_o.ready);
  assign accept       = req_i.valid && req_i.ready;
  assign is_empty_now = (count_q == '0);
  assign is_full_now  = (count_q == CNT_W'(DEPTH));

  // Request decode
  always_comb begin
    ctrl      = '0;
    sel       = count_q;
    count_d   = count_q;
    pop_now   = 1'b0;
    err_now   = 1'b0;
    defer     = 1'b0;
    if (accept) begin
      case (req_i.func)
        FUNC_PUSH_LEFT: begin
          if (is_full_now) begin
            err_now = 1'b1;
          end else begin
            ctrl.shift_right = 1'b1;
            count_d          = count_q + 1'b1;
          end
        end
        FUNC_PUSH_RIGHT: begin
          if (is_full_now) begin
            err_now = 1'b1;
          end else begin
            ctrl.load_sel = 1'b1;
            count_d       = count_q + 1'b1;
          end
        end
        FUNC_POP_LEFT: begin
          if (is_empty_now) begin
            err_now = 1'b1;
          end else begin
            ctrl.shift_left = 1'b1;
            pop_now         = 1'b1;
            count_d         = count_q - 1'b1;
          end
        end
        FUNC_POP_RIGHT: begin
          if (is_empty_now) begin
            err_now = 1'b1;
          end else begin
            ctrl.grab_sel = 1'b1;
            sel           = count_q - 1'b1;
            count_d       = count_q - 1'b1;
            defer         = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
    ctrl.lane_step = busy_q;
  end

  assign write_now = accept && !defer;

  // Response register and pop-right tracking
  always_comb begin
    busy_d      = busy_q;
    out_vld_d   = out_vld_q && !rsp_o.ready;
    out_word_d  = out_word_q;
    out_pv_d    = out_pv_q;
    out_empty_d = out_empty_q;
    out_full_d  = out_full_q;
    out_err_d   = out_err_q;
    if (write_now) begin
      out_vld_d   = 1'b1;
      out_word_d  = pop_now ? head_ext[WORD_W-1:0] : '0;
      out_pv_d    = pop_now;
      out_empty_d = (count_d == '0);
      out_full_d  = (count_d == CNT_W'(DEPTH));
      out_err_d   = err_now;
    end else if (busy_q && lane_vld[0]) begin
      // lane word reached cell 0: deliver the pop-right result
      busy_d      = 1'b0;
      out_vld_d   = 1'b1;
      out_word_d  = lane_ext[WORD_W-1:0];
      out_pv_d    = 1'b1;
      out_empty_d = is_empty_now;
      out_full_d  = is_full_now;
      out_err_d   = 1'b0;
    end
    if (accept && defer) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    out_pv_q    <= out_pv_d;
    out_empty_q <= out_empty_d;
    out_full_q  <= out_full_d;
    out_err_q   <= out_err_d;
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.pop_word  = out_word_q;
  assign rsp_o.pop_valid = out_pv_q;
  assign rsp_o.is_empty  = out_empty_q;
  assign rsp_o.is_full   = out_full_q;
  assign rsp_o.op_error  = out_err_q;

  // Cell row
  assign lane_vld[DEPTH]  = 1'b0;
  assign lane_word[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_word;
    logic [DATA_WIDTH-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = push_word;
    end else begin : g_mid
      assign left_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_inner
      assign right_word = cell_word[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .sel_i        (sel),
      .push_word_i  (push_word),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .word_o       (cell_word[i]),
      .lane_vld_i   (lane_vld[i+1]),
      .lane_word_i  (lane_word[i+1]),
      .lane_vld_o   (lane_vld[i]),
      .lane_word_o  (lane_word[i])
    );
  end

  // Assertions
  logic [DEPTH-1:0] lane_vld_vec;
  for (genvar j = 0; j < DEPTH; j++) begin : g_lane_vec
    assign lane_vld_vec[j] = lane_vld[j];
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_busy_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !out_vld_q)
    else $error("response pending while pop right in flight");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(lane_vld_vec))
    else $error("more than one word on the return lane");

  a_lane_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (lane_vld_vec == '0))
    else $error("return lane active with no pop right in flight");

  a_pop_right_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.func == FUNC_POP_RIGHT && !is_empty_now) |=> busy_q)
    else $error("pop right did not start the return lane");

endmodule
